FILE: rtl/proximity_track_table_defines.svh
// Assertion macros for the proximity track table checker.
`ifndef PROXIMITY_TRACK_TABLE_DEFINES_SVH
`define PROXIMITY_TRACK_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

   // Field widths
   localparam int COORD_W    = 10;
   localparam int CLASS_W    = 4;
   localparam int STAMP_W    = 12;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int DSQ_W      = SQ_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Operation codes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_DETECT = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_DISTANCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECENT_FRAMES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_LIMIT     = 2'd2;

   // Register reset values
   localparam logic [SQ_W-1:0]    RST_RADIUS_SQ     = 20'd2500;
   localparam logic [STAMP_W-1:0] RST_RECENT_FRAMES = 12'd30;
   localparam logic [STAMP_W-1:0] RST_WRAP_LIMIT    = 12'd1000;

   typedef struct packed {
      logic [1:0]         op;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [CLASS_W-1:0] obj_type;
   } req_data_type;

   typedef struct packed {
      logic               already_seen;
      logic [CLASS_W-1:0] nearest_class;
   } rsp_data_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [CLASS_W-1:0] cls;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // Per-entry verdict from the evaluation pipeline
   typedef struct packed {
      logic               vld;
      logic               empty;
      logic               cls_eq;
      logic               eligible;
      logic               in_range;
      logic [DSQ_W-1:0]   dsq;
      logic [CLASS_W-1:0] cls;
   } eval_out_type;

endpackage

`default_nettype wire

FILE: rtl/ptt_entry_ram.sv
`default_nettype none

module ptt_entry_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire ptt_pkg::entry_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output ptt_pkg::entry_type      rd_data
);
   import ptt_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ptt_eval.sv
`default_nettype none

module ptt_eval #(
   parameter int IDX_W = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_vld,
   input  wire logic [IDX_W-1:0]              in_idx,
   input  wire ptt_pkg::entry_type            in_entry,
   input  wire ptt_pkg::req_data_type         item,
   input  wire logic [ptt_pkg::STAMP_W-1:0]   frame_count,
   input  wire logic [ptt_pkg::STAMP_W-1:0]   recent_frames,
   input  wire logic [ptt_pkg::SQ_W-1:0]      radius_sq,
   output ptt_pkg::eval_out_type              res,
   output logic [IDX_W-1:0]                   res_idx,
   output logic                               busy
);
   import ptt_pkg::*;

   logic               a_vld_ff, a_vld_in;
   logic [IDX_W-1:0]   a_idx_ff;
   logic [COORD_W-1:0] a_dx_ff, a_dx_in;
   logic [COORD_W-1:0] a_dy_ff, a_dy_in;
   logic               a_empty_ff, a_empty_in;
   logic               a_cls_eq_ff, a_cls_eq_in;
   logic               a_elig_ff, a_elig_in;
   logic [CLASS_W-1:0] a_cls_ff;

   logic               b_vld_ff;
   logic [IDX_W-1:0]   b_idx_ff;
   logic [SQ_W-1:0]    b_dx2_ff, b_dx2_in;
   logic [SQ_W-1:0]    b_dy2_ff, b_dy2_in;
   logic               b_empty_ff, b_cls_eq_ff, b_elig_ff;
   logic [CLASS_W-1:0] b_cls_ff;

   logic [DSQ_W-1:0]   dsq;

   // Stage A: absolute differences and entry flags
   always_comb begin
      a_vld_in    = in_vld;
      a_dx_in     = (in_entry.x > item.pos_x) ? in_entry.x - item.pos_x
                                              : item.pos_x - in_entry.x;
      a_dy_in     = (in_entry.y > item.pos_y) ? in_entry.y - item.pos_y
                                              : item.pos_y - in_entry.y;
      a_empty_in  = (in_entry.x == '0) && (in_entry.y == '0);
      a_cls_eq_in = (in_entry.cls == item.obj_type);
      // stamped after the counter (wrapped) or still recent
      a_elig_in   = (in_entry.stamp > frame_count) ||
                    ((frame_count - in_entry.stamp) < recent_frames);
   end

   // Stage B: squares
   always_comb begin
      b_dx2_in = SQ_W'(a_dx_ff) * SQ_W'(a_dx_ff);
      b_dy2_in = SQ_W'(a_dy_ff) * SQ_W'(a_dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= a_vld_ff;
      end
      a_idx_ff    <= in_idx;
      a_dx_ff     <= a_dx_in;
      a_dy_ff     <= a_dy_in;
      a_empty_ff  <= a_empty_in;
      a_cls_eq_ff <= a_cls_eq_in;
      a_elig_ff   <= a_elig_in;
      a_cls_ff    <= in_entry.cls;
      b_idx_ff    <= a_idx_ff;
      b_dx2_ff    <= b_dx2_in;
      b_dy2_ff    <= b_dy2_in;
      b_empty_ff  <= a_empty_ff;
      b_cls_eq_ff <= a_cls_eq_ff;
      b_elig_ff   <= a_elig_ff;
      b_cls_ff    <= a_cls_ff;
   end

   // Sum of squares against the squared radius
   assign dsq = {1'b0, b_dx2_ff} + {1'b0, b_dy2_ff};

   always_comb begin
      res.vld      = b_vld_ff;
      res.empty    = b_empty_ff;
      res.cls_eq   = b_cls_eq_ff;
      res.eligible = b_elig_ff;
      res.in_range = (dsq <= {1'b0, radius_sq});
      res.dsq      = dsq;
      res.cls      = b_cls_ff;
   end

   assign res_idx = b_idx_ff;
   assign busy    = a_vld_ff | b_vld_ff;

endmodule

`default_nettype wire

FILE: rtl/proximity_track_table.sv
// Proximity track table. After reset the block runs a clearing pass, one
// entry per cycle, with req_stall high; register writes are taken during
// that pass. A tick or an unused op code goes to the finish state, which
// puts its result in the rsp register once that register is free. A detect
// or lookup op reads the entry memory through its single read port, one
// entry per cycle in index order, and feeds a three-stage compare pipeline
// (read, differences, squares); a detect then writes at most one entry. The
// scan, pipeline drain, detect write and finish states lie between
// acceptance and the result. One item is worked on at a time; the block
// returns to idle as a result enters the rsp register, where it waits while
// the next item is accepted. csr_ready is always high; registers are to be
// written only while the block is idle; the block itself does not enforce
// this.
`default_nettype none

module proximity_track_table #(
   parameter int TABLE_ENTRIES = 128
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire ptt_pkg::req_data_type            req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output ptt_pkg::rsp_data_type                 rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ptt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ptt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ptt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   req_data_type       item_ff, item_in;
   logic [STAMP_W-1:0] fc_ff, fc_in;
   logic [SQ_W-1:0]    r2_ff, r2_in;
   logic [STAMP_W-1:0] recent_ff, recent_in;
   logic [STAMP_W-1:0] wrap_ff, wrap_in;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic               empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]   empty_idx_ff, empty_idx_in;
   logic [DSQ_W-1:0]   best_ff, best_in;
   logic [CLASS_W-1:0] best_cls_ff, best_cls_in;
   logic               res_seen_ff, res_seen_in;
   logic [CLASS_W-1:0] res_cls_ff, res_cls_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   eval_out_type       ev;
   logic [IDX_W-1:0]   ev_idx;
   logic               ev_busy;
   logic [STAMP_W:0]   fc_next;

   // Entry memory
   ptt_entry_ram #(
      .DEPTH (TABLE_ENTRIES),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Compare pipeline
   ptt_eval #(
      .IDX_W (IDX_W)
   ) u_eval (
      .clock         (clock),
      .reset         (reset),
      .in_vld        (rd_vld_ff),
      .in_idx        (rd_idx_ff),
      .in_entry      (rd_data),
      .item          (item_ff),
      .frame_count   (fc_ff),
      .recent_frames (recent_ff),
      .radius_sq     (r2_ff),
      .res           (ev),
      .res_idx       (ev_idx),
      .busy          (ev_busy)
   );

   // Memory ports: clearing pass or detect write-back
   always_comb begin
      rd_en   = (state_ff == ST_SCAN);
      rd_addr = cnt_ff[IDX_W-1:0];
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[IDX_W-1:0];
         wr_data = '0;
      end else begin
         wr_en         = (state_ff == ST_WRITE) && (found_ff || empty_found_ff);
         wr_addr       = found_ff ? found_idx_ff : empty_idx_ff;
         wr_data.x     = item_ff.pos_x;
         wr_data.y     = item_ff.pos_y;
         wr_data.cls   = item_ff.obj_type;
         wr_data.stamp = fc_ff;
      end
   end

   // Frame counter advance
   assign fc_next = {1'b0, fc_ff} + 1'b1;

   // Next-state logic
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      item_in        = item_ff;
      fc_in          = fc_ff;
      r2_in          = r2_ff;
      recent_in      = recent_ff;
      wrap_in        = wrap_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      best_in        = best_ff;
      best_cls_in    = best_cls_ff;
      res_seen_in    = res_seen_ff;
      res_cls_in     = res_cls_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      // result register drains
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_MATCH_DISTANCE: r2_in = SQ_W'(csr_wdata[COORD_W-1:0]) *
                                        SQ_W'(csr_wdata[COORD_W-1:0]);
            CSR_RECENT_FRAMES:  recent_in = csr_wdata[STAMP_W-1:0];
            CSR_WRAP_LIMIT:     wrap_in   = csr_wdata[STAMP_W-1:0];
            default: ;
         endcase
      end

      // per-entry verdicts
      if (ev.vld) begin
         if (item_ff.op == OP_DETECT) begin
            if (!found_ff && !ev.empty && ev.cls_eq && ev.in_range && ev.eligible) begin
               found_in     = 1'b1;
               found_idx_in = ev_idx;
            end
            if (ev.empty && !empty_found_ff) begin
               empty_found_in = 1'b1;
               empty_idx_in   = ev_idx;
            end
         end else begin
            // nearest entry; strict compare keeps the lowest index on ties
            if (!ev.empty && ev.in_range && (!found_ff || (ev.dsq < best_ff))) begin
               found_in    = 1'b1;
               best_in     = ev.dsq;
               best_cls_in = ev.cls;
            end
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in     = req_data;
               res_seen_in = 1'b0;
               res_cls_in  = '0;
               case (req_data.op)
                  OP_TICK: begin
                     fc_in    = (fc_next > {1'b0, wrap_ff}) ? '0 : fc_next[STAMP_W-1:0];
                     state_in = ST_FINISH;
                  end
                  OP_DETECT, OP_LOOKUP: begin
                     cnt_in         = '0;
                     found_in       = 1'b0;
                     empty_found_in = 1'b0;
                     best_cls_in    = '0;
                     state_in       = ST_SCAN;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !ev_busy) begin
               if (item_ff.op == OP_DETECT) begin
                  state_in = ST_WRITE;
               end else begin
                  res_cls_in = best_cls_ff;
                  state_in   = ST_FINISH;
               end
            end
         end
         ST_WRITE: begin
            res_seen_in = found_ff;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.already_seen  = res_seen_ff;
               rsp_data_in.nearest_class = res_cls_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State, counters and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         cnt_ff         <= '0;
         fc_ff          <= '0;
         r2_ff          <= RST_RADIUS_SQ;
         recent_ff      <= RST_RECENT_FRAMES;
         wrap_ff        <= RST_WRAP_LIMIT;
         rd_vld_ff      <= 1'b0;
         found_ff       <= 1'b0;
         empty_found_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         fc_ff          <= fc_in;
         r2_ff          <= r2_in;
         recent_ff      <= recent_in;
         wrap_ff        <= wrap_in;
         rd_vld_ff      <= rd_en;
         found_ff       <= found_in;
         empty_found_ff <= empty_found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      item_ff      <= item_in;
      rd_idx_ff    <= rd_addr;
      found_idx_ff <= found_idx_in;
      empty_idx_ff <= empty_idx_in;
      best_ff      <= best_in;
      best_cls_ff  <= best_cls_in;
      res_seen_ff  <= res_seen_in;
      res_cls_ff   <= res_cls_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/ptt_checker.sv
`default_nettype none

`include "proximity_track_table_defines.svh"

module ptt_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire ptt_pkg::req_data_type req_data,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire ptt_pkg::rsp_data_type rsp_data
);
   import ptt_pkg::*;

   // a stalled result item holds
   `PTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp item changed while stalled")

   // one item at a time: busy right after an accept
   `PTT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "req accepted while previous item in work")

   // the clearing pass holds off items after reset
   `PTT_ASSERT_NOW(a_clear_after_reset, $past(reset), req_stall, "req taken during clearing pass")

   // only one of the two result fields can be set
   `PTT_ASSERT_NOW(a_fields_exclusive, rsp_valid, !rsp_data.already_seen || (rsp_data.nearest_class == '0), "seen and class both set")

endmodule

bind proximity_track_table ptt_checker u_ptt_checker (.*);

`default_nettype wire
